// ----- hdl/sc_pkg.sv -----
// Shared types and constants for the stack calculator.
package sc_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int ACT_W       = 3;
    localparam int STAT_W      = 2;

    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH = 3'd0,
        ACT_ADD  = 3'd1,
        ACT_MUL  = 3'd2,
        ACT_DUP  = 3'd3,
        ACT_DROP = 3'd4
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;  // capture command word, start operand read
        logic exec;  // apply command to the stack, load result
    } ctrl_cmd_t;

endpackage

// ----- hdl/sc_cmd_if.sv -----
// Command channel: action and operand with valid/ready handshake.
interface sc_cmd_if;
    import sc_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

// ----- hdl/sc_res_if.sv -----
// Result channel: top entry, depth and status with valid/ready handshake.
interface sc_res_if;
    import sc_pkg::*;

    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  top_value;
    logic [DEPTH_W-1:0] depth;
    logic [STAT_W-1:0]  status;

    modport source (output valid, output top_value, output depth, output status, input ready);
    modport sink   (input valid, input top_value, input depth, input status, output ready);
endinterface

// ----- hdl/sc_ctrl.sv -----
// Controller state machine: sequences accept, execute and result hand-off.
module sc_ctrl
    import sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/sc_dpath.sv -----
// Datapath: top-of-stack register, entry store, ALU and result registers.
module sc_dpath
    import sc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    input  logic [ACT_W-1:0]   action,
    input  logic [DATA_W-1:0]  value,
    output logic [DATA_W-1:0]  res_top,
    output logic [DEPTH_W-1:0] res_depth,
    output logic [STAT_W-1:0]  res_status
);

    // Entries below the top; the top itself lives in top_reg.
    logic [DATA_W-1:0] mem [STACK_DEPTH];

    logic [ACT_W-1:0]   act_reg;
    logic [DATA_W-1:0]  val_reg;
    logic [DATA_W-1:0]  rd_data_reg;
    logic [DATA_W-1:0]  top_reg;
    logic [DATA_W-1:0]  top_next;
    logic [DEPTH_W-1:0] count_reg;
    logic [DEPTH_W-1:0] count_next;
    logic [DATA_W-1:0]  res_top_reg;
    logic [DEPTH_W-1:0] res_depth_reg;
    status_t            res_status_reg;
    status_t            status_next;

    logic               wr_en;
    logic [DEPTH_W-1:0] count_m1;
    logic [DEPTH_W-1:0] count_m2;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [DATA_W-1:0]  sum;
    logic [DATA_W-1:0]  prod;

    assign count_m1 = count_reg - DEPTH_W'(1);
    assign count_m2 = count_reg - DEPTH_W'(2);
    assign wr_addr  = count_m1[ADDR_W-1:0];
    assign rd_addr  = count_m2[ADDR_W-1:0];
    assign sum      = rd_data_reg + top_reg;
    assign prod     = rd_data_reg * top_reg;

    always_comb
    begin
        top_next    = top_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        wr_en       = 1'b0;
        unique case (act_reg)
            ACT_PUSH:
            begin
                if (count_reg == DEPTH_FULL)
                begin
                    status_next = ST_OVER;
                end
                else
                begin
                    wr_en      = (count_reg != '0);
                    top_next   = val_reg;
                    count_next = count_reg + DEPTH_W'(1);
                end
            end
            ACT_ADD, ACT_MUL:
            begin
                if (count_reg < DEPTH_W'(2))
                begin
                    status_next = ST_UNDER;
                end
                else
                begin
                    top_next   = (act_reg == ACT_ADD) ? sum : prod;
                    count_next = count_m1;
                end
            end
            ACT_DUP:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_UNDER;
                end
                else if (count_reg == DEPTH_FULL)
                begin
                    status_next = ST_OVER;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + DEPTH_W'(1);
                end
            end
            ACT_DROP:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_UNDER;
                end
                else
                begin
                    top_next   = rd_data_reg;
                    count_next = count_m1;
                end
            end
            default:
            begin
                status_next = ST_OK;  // unused codes leave the stack alone
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg     <= action;
            val_reg     <= value;
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= top_reg;  // old top sinks into the store
        end
        if (cmd.exec)
        begin
            top_reg        <= top_next;
            res_top_reg    <= (count_next == '0) ? '0 : top_next;
            res_depth_reg  <= count_next;
            res_status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign res_top    = res_top_reg;
    assign res_depth  = res_depth_reg;
    assign res_status = res_status_reg;

endmodule

// ----- hdl/stack_calculator.sv -----
// Integer stack calculator: push, add, multiply, duplicate and drop on a
// 16-entry stack of 32-bit words. Each command word yields one result word
// with the new top entry (zero when empty), the depth and a status (ok,
// underflow, overflow; the stack is unchanged on error). One command is in
// flight at a time and goes through these steps from acceptance to result:
// an accept cycle that issues the registered read of the second entry, an
// execute cycle through the adder or the 32x32 multiplier into the top
// register, and the result cycle. The next command word is taken in the
// cycle after the result word is taken, so no new command word is accepted
// while a result word waits to be taken.
module stack_calculator
    import sc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    sc_cmd_if.sink  cmd,
    sc_res_if.source res
);

    ctrl_cmd_t ctrl_cmd;

    sc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (ctrl_cmd)
    );

    sc_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctrl_cmd),
        .action     (cmd.action),
        .value      (cmd.value),
        .res_top    (res.top_value),
        .res_depth  (res.depth),
        .res_status (res.status)
    );

    // one command in flight: never ready for a new word while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !cmd.ready)
        else $error("command accepted while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.depth <= DEPTH_FULL))
        else $error("reported depth exceeds stack size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.depth == '0)) |-> (res.top_value == '0))
        else $error("nonzero top reported on empty stack");

    // an accepted command raises result valid once the execute state has passed
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> ##1 $rose(res.valid))
        else $error("result not presented after execute");

endmodule

// ----- tb/sv/tb_stack_calculator.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the stack calculator: directed corner cases, then random programs.
module tb_stack_calculator;
    import sc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 20;

    // action codes outside the defined set act as a no-op
    localparam logic [ACT_W-1:0] ACT_NOP_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_NOP_HI = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0]  top;
        logic [DEPTH_W-1:0] depth;
        status_t            status;
    } calc_result_t;

    logic clk = 1'b0;
    logic rst_n;

    always #10 clk = ~clk;

    sc_cmd_if cmd_bus();
    sc_res_if res_bus();

    stack_calculator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
    int                calc_count = 0;
    calc_result_t      expected_q [$];
    int                mismatch_count = 0;
    int                cycle_count = 0;
    bit                send_idle_on = 1'b1;
    bit                recv_idle_on = 1'b1;

    // Apply one command to the shadow stack and return the word the block must produce.
    function automatic calc_result_t apply_command(logic [ACT_W-1:0] act,
                                                   logic [DATA_W-1:0] val);
        calc_result_t r;
        status_t      st;
        st = ST_OK;
        case (act)
            ACT_PUSH:
                if (calc_count >= STACK_DEPTH)
                    st = ST_OVER;
                else
                begin
                    calc_stack[calc_count] = val;
                    calc_count++;
                end
            ACT_ADD, ACT_MUL:
                if (calc_count < 2)
                    st = ST_UNDER;
                else
                begin
                    if (act == ACT_ADD)
                        calc_stack[calc_count-2] = calc_stack[calc_count-1]
                                                 + calc_stack[calc_count-2];
                    else
                        calc_stack[calc_count-2] = calc_stack[calc_count-1]
                                                 * calc_stack[calc_count-2];
                    calc_count--;
                end
            ACT_DUP:
                if (calc_count == 0)
                    st = ST_UNDER;
                else if (calc_count >= STACK_DEPTH)
                    st = ST_OVER;
                else
                begin
                    calc_stack[calc_count] = calc_stack[calc_count-1];
                    calc_count++;
                end
            ACT_DROP:
                if (calc_count == 0)
                    st = ST_UNDER;
                else
                    calc_count--;
            default: ;
        endcase
        r.top    = (calc_count > 0) ? calc_stack[calc_count-1] : '0;
        r.depth  = DEPTH_W'(calc_count);
        r.status = st;
        return r;
    endfunction

    function automatic int draw_gap(bit idle_on);
        if (!idle_on)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // Growing phase favors push/dup, shrinking phase favors add/mul/drop.
    function automatic logic [ACT_W-1:0] pick_action(bit climbing);
        int r;
        r = $urandom_range(0, 99);
        if (climbing)
        begin
            if (r < 50) return ACT_PUSH;
            if (r < 65) return ACT_DUP;
            if (r < 75) return ACT_ADD;
            if (r < 85) return ACT_MUL;
            if (r < 93) return ACT_DROP;
        end
        else
        begin
            if (r < 10) return ACT_PUSH;
            if (r < 15) return ACT_DUP;
            if (r < 37) return ACT_ADD;
            if (r < 59) return ACT_MUL;
            if (r < 90) return ACT_DROP;
        end
        return ACT_W'($urandom_range(ACT_NOP_LO, ACT_NOP_HI));
    endfunction

    // Valid is left high after acceptance; the next call either loads a new word
    // in the same step or lowers valid for its gap.
    task automatic send_cmd(logic [ACT_W-1:0] act, logic [DATA_W-1:0] val);
        int gap;
        gap = draw_gap(send_idle_on);
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid  <= 1'b1;
        cmd_bus.action <= act;
        cmd_bus.value  <= val;
        do
            @(posedge clk);
        while (!(cmd_bus.valid && cmd_bus.ready));
        expected_q.push_back(apply_command(act, val));
    endtask

    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result();
        calc_result_t got;
        calc_result_t want;
        got.top    = res_bus.top_value;
        got.depth  = res_bus.depth;
        got.status = status_t'(res_bus.status);
        if (expected_q.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected result word: top=%h depth=%0d status=%0d",
                         got.top, got.depth, got.status);
        end
        else
        begin
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("mismatch exp top=%h depth=%0d st=%0d got top=%h depth=%0d st=%0d",
                             want.top, want.depth, want.status,
                             got.top, got.depth, got.status);
            end
        end
    endtask

    // Every command but push on an empty stack, including the unused codes.
    task automatic test_empty_stack();
        send_cmd(ACT_ADD, 32'hffff_ffff);
        send_cmd(ACT_MUL, 32'h8000_0000);
        send_cmd(ACT_DUP, 32'h7fff_ffff);
        send_cmd(ACT_DROP, 32'h0000_0000);
        for (int c = ACT_NOP_LO; c <= ACT_NOP_HI; c++)
            send_cmd(ACT_W'(c), $urandom);
    endtask

    // Wraparound on add and multiply, single-entry underflow, dropping the last entry.
    task automatic test_wrap_extremes();
        send_cmd(ACT_PUSH, 32'h7fff_ffff);
        send_cmd(ACT_ADD, 32'h0000_0000);
        send_cmd(ACT_MUL, 32'h0000_0000);
        send_cmd(ACT_PUSH, 32'h0000_0001);
        send_cmd(ACT_ADD, 32'hffff_ffff);
        send_cmd(ACT_PUSH, 32'hffff_ffff);
        send_cmd(ACT_MUL, 32'h1234_5678);
        send_cmd(ACT_DUP, 32'h0000_0000);
        send_cmd(ACT_ADD, 32'h0000_0000);
        send_cmd(ACT_PUSH, 32'h8000_0000);
        send_cmd(ACT_NOP_HI, 32'h0000_0000);
        send_cmd(ACT_DROP, 32'h0000_0000);
        send_cmd(ACT_DROP, 32'h0000_0000);
        send_cmd(ACT_DROP, 32'h0000_0000);
    endtask

    // Fill to the top, hit overflow on push and dup, then unwind to empty.
    task automatic test_fill_overflow();
        while (calc_count < STACK_DEPTH)
            send_cmd(ACT_PUSH, pick_value());
        send_cmd(ACT_PUSH, pick_value());
        send_cmd(ACT_DUP, pick_value());
        send_cmd(ACT_NOP_LO, pick_value());
        wait_drained();
        send_cmd(ACT_MUL, pick_value());
        send_cmd(ACT_DUP, pick_value());
        while (calc_count > 1)
            send_cmd(($urandom_range(0, 1) != 0) ? ACT_DROP : ACT_ADD, pick_value());
        send_cmd(ACT_DROP, pick_value());
        send_cmd(ACT_DROP, pick_value());
    endtask

    task automatic test_random_programs(int n_items, bit vary_idle);
        bit climbing;
        climbing = 1'b1;
        for (int i = 0; i < n_items; i++)
        begin
            if (vary_idle && $urandom_range(0, 63) == 0)
            begin
                send_idle_on = ($urandom_range(0, 3) != 0);
                recv_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (calc_count >= STACK_DEPTH && $urandom_range(0, 2) == 0)
                climbing = 1'b0;
            else if (calc_count <= 1 && $urandom_range(0, 1) == 0)
                climbing = 1'b1;
            else if ($urandom_range(0, 30) == 0)
                climbing = !climbing;
            send_cmd(pick_action(climbing), pick_value());
        end
    endtask

    task automatic test_back_to_back();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        test_random_programs(150, 1'b0);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL stack_calculator");
            $finish;
        end
    end

    // Result side: random stall before each word, then take it and compare.
    initial
    begin
        int stall;
        res_bus.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = draw_gap(recv_idle_on);
            if (stall > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res_bus.valid && res_bus.ready));
            check_result();
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        cmd_bus.valid  <= 1'b0;
        cmd_bus.action <= ACT_PUSH;
        cmd_bus.value  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_stack();
        test_wrap_extremes();
        test_fill_overflow();
        test_back_to_back();
        test_random_programs(1150, 1'b1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("PASS stack_calculator");
        else
            $display("FAIL stack_calculator");
        $finish;
    end

endmodule
